/* design/imsc_pkg.sv */
// ============================================================================
// imsc_pkg: shared types and constants for the IMU / magnetometer conditioner
// Field widths, register map codes, status bit positions, control structs.
// ============================================================================
package imsc_pkg;

    // register bus
    localparam int AddrW = 6;
    localparam int DataW = 64;

    // register map (index = paddr[5:3])
    localparam logic [2:0] REG_IMU_PRESENT = 3'd0;
    localparam logic [2:0] REG_MAG_PRESENT = 3'd1;
    localparam logic [2:0] REG_MISS_LIMIT  = 3'd2;
    localparam logic [2:0] REG_CAL_ROW0    = 3'd3;
    localparam logic [2:0] REG_CAL_ROW1    = 3'd4;
    localparam logic [2:0] REG_CAL_ROW2    = 3'd5;
    localparam logic [2:0] REG_CAL_OFFSET  = 3'd6;

    // frame kinds
    localparam logic KIND_IMU = 1'b0;
    localparam logic KIND_MAG = 1'b1;

    // status bits
    localparam int DrdyBit = 0;
    localparam int OvfBit  = 3;

    // miss counter
    localparam logic [7:0] MissLimitRst = 8'd50;
    localparam logic [7:0] MissMax      = 8'hFF;

    // widths
    localparam int BytesW = 48;
    localparam int AxisW  = 16;   // raw axis
    localparam int NegW   = 17;   // negated axis
    localparam int CoefW  = 21;   // Q24 matrix coefficient
    localparam int RowW   = 3 * CoefW;
    localparam int OffW   = 20;   // Q4 offset
    localparam int OffsW  = 3 * OffW;
    localparam int DiffW  = 22;   // 16*m - b
    localparam int ProdW  = CoefW + DiffW;
    localparam int SumW   = ProdW + 2;
    localparam int FracDrop = 12;   // Q28 -> Q16
    localparam int QW     = SumW - FracDrop;
    localparam int MagW   = 24;
    localparam int MagMax = (1 << (MagW - 1)) - 1;
    localparam int MagMin = -(1 << (MagW - 1));

    typedef logic signed [DiffW-1:0] t_diff;
    typedef logic signed [MagW-1:0]  t_mag;

    // pipeline enables for the calibration datapath
    typedef struct packed {
        logic prod_en;   // load products
        logic sum_en;    // load result
        logic keep;      // result is a valid mag sample, else zero
    } t_cal_ctl;

    // sensor health, as seen by the item being accepted
    typedef struct packed {
        logic       imu_work;
        logic       mag_work;
        logic [1:0] alive_next;
    } t_health;

endpackage

/* design/imsc_health.sv */
// ============================================================================
// imsc_health: per-sensor miss counters and alive flags
// Counts consecutive failed reads; a sensor dies once its count passes the limit.
// ============================================================================
module imsc_health (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_action,
    input  logic                 i_read_ok,
    input  logic                 i_sample_good,
    input  logic                 i_imu_present,
    input  logic                 i_mag_present,
    input  logic [7:0]           i_miss_limit,
    output imsc_pkg::t_health    o_health
);

    logic       r_imu_alive, n_imu_alive;
    logic       r_mag_alive, n_mag_alive;
    logic [7:0] r_imu_misses, n_imu_misses;
    logic [7:0] r_mag_misses, n_mag_misses;
    logic [7:0] imu_bump, mag_bump;
    logic       imu_work, mag_work;

    assign imu_work = i_imu_present & r_imu_alive;
    assign mag_work = i_mag_present & r_mag_alive;
    assign imu_bump = (r_imu_misses != imsc_pkg::MissMax) ? r_imu_misses + 8'd1
                                                          : imsc_pkg::MissMax;
    assign mag_bump = (r_mag_misses != imsc_pkg::MissMax) ? r_mag_misses + 8'd1
                                                          : imsc_pkg::MissMax;

    always_comb begin
        n_imu_alive  = r_imu_alive;
        n_mag_alive  = r_mag_alive;
        n_imu_misses = r_imu_misses;
        n_mag_misses = r_mag_misses;
        if (i_take && (i_action == imsc_pkg::KIND_IMU) && imu_work) begin
            if (i_read_ok) begin
                n_imu_misses = '0;
            end else begin
                n_imu_misses = imu_bump;
                if (imu_bump > i_miss_limit) begin
                    n_imu_alive = 1'b0;
                end
            end
        end
        if (i_take && (i_action == imsc_pkg::KIND_MAG) && mag_work) begin
            if (!i_read_ok) begin
                n_mag_misses = mag_bump;
                if (mag_bump > i_miss_limit) begin
                    n_mag_alive = 1'b0;
                end
            end else if (i_sample_good) begin
                n_mag_misses = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imu_alive  <= 1'b1;
            r_mag_alive  <= 1'b1;
            r_imu_misses <= '0;
            r_mag_misses <= '0;
        end else begin
            r_imu_alive  <= n_imu_alive;
            r_mag_alive  <= n_mag_alive;
            r_imu_misses <= n_imu_misses;
            r_mag_misses <= n_mag_misses;
        end
    end

    assign o_health.imu_work   = imu_work;
    assign o_health.mag_work   = mag_work;
    assign o_health.alive_next = {i_mag_present & n_mag_alive, i_imu_present & n_imu_alive};

endmodule

/* design/imsc_cal.sv */
// ============================================================================
// imsc_cal: 3x3 soft-iron matrix times offset-corrected field
// Nine registered products, then sum, round half up to Q16 and saturate.
// ============================================================================
module imsc_cal (
    input  logic                                        i_clk,
    input  imsc_pkg::t_cal_ctl                          i_ctl,
    input  logic [2:0][imsc_pkg::DiffW-1:0]             i_diff,
    input  logic [2:0][imsc_pkg::RowW-1:0]              i_rows,
    output logic [2:0][imsc_pkg::MagW-1:0]              o_mag
);

    logic signed [imsc_pkg::ProdW-1:0] r_prod [3][3];
    logic signed [imsc_pkg::SumW-1:0]  sum    [3];
    logic signed [imsc_pkg::QW-1:0]    q      [3];
    imsc_pkg::t_mag                    sat    [3];
    imsc_pkg::t_mag                    r_mag  [3];

    // products: coefficient (Q24) times difference (Q4)
    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= $signed(i_rows[r][imsc_pkg::CoefW*c +: imsc_pkg::CoefW])
                                  * $signed(i_diff[c]);
                end
            end
        end
    end

    // sum (Q28), round half up, floor shift to Q16, clamp
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = imsc_pkg::SumW'(r_prod[r][0]) + imsc_pkg::SumW'(r_prod[r][1])
                   + imsc_pkg::SumW'(r_prod[r][2])
                   + imsc_pkg::SumW'(1 << (imsc_pkg::FracDrop - 1));
            q[r]   = imsc_pkg::QW'(sum[r] >>> imsc_pkg::FracDrop);
            if (q[r] > imsc_pkg::QW'(imsc_pkg::MagMax)) begin
                sat[r] = imsc_pkg::MagW'(imsc_pkg::MagMax);
            end else if (q[r] < imsc_pkg::QW'(imsc_pkg::MagMin)) begin
                sat[r] = imsc_pkg::MagW'(imsc_pkg::MagMin);
            end else begin
                sat[r] = q[r][imsc_pkg::MagW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            for (int r = 0; r < 3; r++) begin
                r_mag[r] <= i_ctl.keep ? sat[r] : '0;
            end
        end
    end

    assign o_mag[0] = r_mag[0];
    assign o_mag[1] = r_mag[1];
    assign o_mag[2] = r_mag[2];

endmodule

/* design/imu_mag_sample_conditioner.sv */
// ============================================================================
// imu_mag_sample_conditioner: accel/gyro decode and magnetometer calibration
// Decodes one finished burst read per word, tracks sensor health and applies
// hard/soft-iron calibration A*(m - b) to magnetometer samples.
// ============================================================================
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  input     | i_valid / o_ready  | i_action, i_read_ok, i_*_bytes, i_mag_status*
//  output    | o_valid / i_ready  | o_kind, o_accel_*, o_gyro_*, o_mag_*, o_fresh,
//            |                    | o_alive_flags
//  config    | APB psel/penable   | paddr (8-byte aligned), pwdata, prdata
//
//  Throughput: one word per cycle while the output is not stalled. From accept
//  to o_valid a word passes the decode/offset, product and result registers.
//  Health state (miss counters, alive bits) updates at the accept edge, so the
//  next word sees it with no bubble.
//  Reset (i_rst_n low, synchronous) empties the pipeline and restores config
//  and health defaults. Output stalls back up through the stages; o_ready
//  stays high while any stage ahead has room.
//
module imu_mag_sample_conditioner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic                          i_read_ok,
    input  logic [imsc_pkg::BytesW-1:0]   i_accel_bytes,
    input  logic [imsc_pkg::BytesW-1:0]   i_gyro_bytes,
    input  logic [imsc_pkg::BytesW-1:0]   i_mag_bytes,
    input  logic [7:0]                    i_mag_status1,
    input  logic [7:0]                    i_mag_status2,
    // output words
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic signed [imsc_pkg::NegW-1:0]  o_accel_x,
    output logic signed [imsc_pkg::AxisW-1:0] o_accel_y,
    output logic signed [imsc_pkg::NegW-1:0]  o_accel_z,
    output logic signed [imsc_pkg::NegW-1:0]  o_gyro_x,
    output logic signed [imsc_pkg::AxisW-1:0] o_gyro_y,
    output logic signed [imsc_pkg::NegW-1:0]  o_gyro_z,
    output logic signed [imsc_pkg::MagW-1:0]  o_mag_x,
    output logic signed [imsc_pkg::MagW-1:0]  o_mag_y,
    output logic signed [imsc_pkg::MagW-1:0]  o_mag_z,
    output logic                          o_fresh,
    output logic [1:0]                    o_alive_flags,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imsc_pkg::AddrW-1:0]    paddr,
    input  logic [imsc_pkg::DataW-1:0]    pwdata,
    output logic [imsc_pkg::DataW-1:0]    prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                                    r_imu_present;
    logic                                    r_mag_present;
    logic [7:0]                              r_miss_limit;
    logic [2:0][imsc_pkg::RowW-1:0]          r_cal_row;
    logic [imsc_pkg::OffsW-1:0]              r_cal_offset;
    logic                                    cfg_wr;
    logic [2:0]                              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imu_present <= 1'b1;
            r_mag_present <= 1'b1;
            r_miss_limit  <= imsc_pkg::MissLimitRst;
            r_cal_row     <= '0;
            r_cal_offset  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                imsc_pkg::REG_IMU_PRESENT: r_imu_present <= pwdata[0];
                imsc_pkg::REG_MAG_PRESENT: r_mag_present <= pwdata[0];
                imsc_pkg::REG_MISS_LIMIT:  r_miss_limit  <= pwdata[7:0];
                imsc_pkg::REG_CAL_ROW0:    r_cal_row[0]  <= pwdata[imsc_pkg::RowW-1:0];
                imsc_pkg::REG_CAL_ROW1:    r_cal_row[1]  <= pwdata[imsc_pkg::RowW-1:0];
                imsc_pkg::REG_CAL_ROW2:    r_cal_row[2]  <= pwdata[imsc_pkg::RowW-1:0];
                imsc_pkg::REG_CAL_OFFSET:  r_cal_offset  <= pwdata[imsc_pkg::OffsW-1:0];
                default: ;   // unmapped slot, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            imsc_pkg::REG_IMU_PRESENT: prdata = imsc_pkg::DataW'(r_imu_present);
            imsc_pkg::REG_MAG_PRESENT: prdata = imsc_pkg::DataW'(r_mag_present);
            imsc_pkg::REG_MISS_LIMIT:  prdata = imsc_pkg::DataW'(r_miss_limit);
            imsc_pkg::REG_CAL_ROW0:    prdata = imsc_pkg::DataW'(r_cal_row[0]);
            imsc_pkg::REG_CAL_ROW1:    prdata = imsc_pkg::DataW'(r_cal_row[1]);
            imsc_pkg::REG_CAL_ROW2:    prdata = imsc_pkg::DataW'(r_cal_row[2]);
            imsc_pkg::REG_CAL_OFFSET:  prdata = imsc_pkg::DataW'(r_cal_offset);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic en1, en2, en3, take;
    logic r1_valid, r2_valid, r3_valid;

    assign en3     = !r3_valid | i_ready;
    assign en2     = !r2_valid | en3;
    assign en1     = !r1_valid | en2;
    assign o_ready = en1;
    assign take    = i_valid & en1;

    // ------------------------------------------------------------------
    // accept stage: health, axis decode, offset subtraction
    // ------------------------------------------------------------------
    imsc_pkg::t_health health;
    logic sample_good, imu_ok, mag_ok, fresh;

    // data ready set, overflow clear
    assign sample_good = i_mag_status1[imsc_pkg::DrdyBit] & !i_mag_status2[imsc_pkg::OvfBit];

    imsc_health u_health (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_action      (i_action),
        .i_read_ok     (i_read_ok),
        .i_sample_good (sample_good),
        .i_imu_present (r_imu_present),
        .i_mag_present (r_mag_present),
        .i_miss_limit  (r_miss_limit),
        .o_health      (health)
    );

    assign imu_ok = (i_action == imsc_pkg::KIND_IMU) & health.imu_work & i_read_ok;
    assign mag_ok = (i_action == imsc_pkg::KIND_MAG) & health.mag_work & i_read_ok
                  & sample_good;
    assign fresh  = imu_ok | mag_ok;

    // accel/gyro: big-endian pairs, x at the top; x and z negated
    logic signed [imsc_pkg::AxisW-1:0] acc_raw [3];
    logic signed [imsc_pkg::AxisW-1:0] gyr_raw [3];
    logic signed [imsc_pkg::AxisW-1:0] mag_raw [3];
    logic signed [imsc_pkg::NegW-1:0]  mag_m   [3];
    logic [2:0][imsc_pkg::DiffW-1:0]   diff;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_raw[i] = i_accel_bytes[imsc_pkg::BytesW-1-16*i -: imsc_pkg::AxisW];
            gyr_raw[i] = i_gyro_bytes[imsc_pkg::BytesW-1-16*i -: imsc_pkg::AxisW];
            // little-endian pair: low byte first
            mag_raw[i] = {i_mag_bytes[imsc_pkg::BytesW-9-16*i -: 8],
                          i_mag_bytes[imsc_pkg::BytesW-1-16*i -: 8]};
        end
        // sensor frame to body frame: x' = -y, y' = x, z' = z
        mag_m[0] = -imsc_pkg::NegW'(mag_raw[1]);
        mag_m[1] = imsc_pkg::NegW'(mag_raw[0]);
        mag_m[2] = imsc_pkg::NegW'(mag_raw[2]);
        // d = 16*m - b, exact in Q4
        for (int c = 0; c < 3; c++) begin
            diff[c] = imsc_pkg::DiffW'($signed({mag_m[c], 4'b0000}))
                    - imsc_pkg::DiffW'($signed(r_cal_offset[imsc_pkg::OffW*c +: imsc_pkg::OffW]));
        end
    end

    logic                              r1_kind, r1_fresh, r1_mag_ok;
    logic [1:0]                        r1_alive;
    logic signed [imsc_pkg::NegW-1:0]  r1_acc_x, r1_acc_z, r1_gyr_x, r1_gyr_z;
    logic signed [imsc_pkg::AxisW-1:0] r1_acc_y, r1_gyr_y;
    logic [2:0][imsc_pkg::DiffW-1:0]   r1_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r1_kind   <= i_action;
            r1_fresh  <= fresh;
            r1_mag_ok <= mag_ok;
            r1_alive  <= health.alive_next;
            r1_diff   <= diff;
            // accel/gyro fields read zero unless this is a good IMU frame
            r1_acc_x  <= imu_ok ? -imsc_pkg::NegW'(acc_raw[0]) : '0;
            r1_acc_y  <= imu_ok ? acc_raw[1] : '0;
            r1_acc_z  <= imu_ok ? -imsc_pkg::NegW'(acc_raw[2]) : '0;
            r1_gyr_x  <= imu_ok ? -imsc_pkg::NegW'(gyr_raw[0]) : '0;
            r1_gyr_y  <= imu_ok ? gyr_raw[1] : '0;
            r1_gyr_z  <= imu_ok ? -imsc_pkg::NegW'(gyr_raw[2]) : '0;
        end
    end

    // ------------------------------------------------------------------
    // stage 2 / 3: side-band payload rides along the calibration pipe
    // ------------------------------------------------------------------
    logic                              r2_kind, r2_fresh, r2_mag_ok;
    logic [1:0]                        r2_alive;
    logic signed [imsc_pkg::NegW-1:0]  r2_acc_x, r2_acc_z, r2_gyr_x, r2_gyr_z;
    logic signed [imsc_pkg::AxisW-1:0] r2_acc_y, r2_gyr_y;

    logic                              r3_kind, r3_fresh;
    logic [1:0]                        r3_alive;
    logic signed [imsc_pkg::NegW-1:0]  r3_acc_x, r3_acc_z, r3_gyr_x, r3_gyr_z;
    logic signed [imsc_pkg::AxisW-1:0] r3_acc_y, r3_gyr_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_kind   <= r1_kind;
            r2_fresh  <= r1_fresh;
            r2_mag_ok <= r1_mag_ok;
            r2_alive  <= r1_alive;
            r2_acc_x  <= r1_acc_x;
            r2_acc_y  <= r1_acc_y;
            r2_acc_z  <= r1_acc_z;
            r2_gyr_x  <= r1_gyr_x;
            r2_gyr_y  <= r1_gyr_y;
            r2_gyr_z  <= r1_gyr_z;
        end
        if (en3) begin
            r3_kind   <= r2_kind;
            r3_fresh  <= r2_fresh;
            r3_alive  <= r2_alive;
            r3_acc_x  <= r2_acc_x;
            r3_acc_y  <= r2_acc_y;
            r3_acc_z  <= r2_acc_z;
            r3_gyr_x  <= r2_gyr_x;
            r3_gyr_y  <= r2_gyr_y;
            r3_gyr_z  <= r2_gyr_z;
        end
    end

    // calibration: products load with stage 2, result with stage 3
    imsc_pkg::t_cal_ctl              cal_ctl;
    logic [2:0][imsc_pkg::MagW-1:0]  cal_mag;

    assign cal_ctl.prod_en = en2;
    assign cal_ctl.sum_en  = en3;
    assign cal_ctl.keep    = r2_mag_ok;

    imsc_cal u_cal (
        .i_clk  (i_clk),
        .i_ctl  (cal_ctl),
        .i_diff (r1_diff),
        .i_rows (r_cal_row),
        .o_mag  (cal_mag)
    );

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign o_valid       = r3_valid;
    assign o_kind        = r3_kind;
    assign o_fresh       = r3_fresh;
    assign o_alive_flags = r3_alive;
    assign o_accel_x     = r3_acc_x;
    assign o_accel_y     = r3_acc_y;
    assign o_accel_z     = r3_acc_z;
    assign o_gyro_x      = r3_gyr_x;
    assign o_gyro_y      = r3_gyr_y;
    assign o_gyro_z      = r3_gyr_z;
    assign o_mag_x       = cal_mag[0];
    assign o_mag_y       = cal_mag[1];
    assign o_mag_z       = cal_mag[2];

endmodule

/* design/imsc_checker.sv */
// ============================================================================
// imsc_checker: port-level checks for the sample conditioner
// Output pipe empties on reset; data fields stay zero where no vector is due.
// ============================================================================
module imsc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_kind,
    input logic                              o_fresh,
    input logic signed [imsc_pkg::NegW-1:0]  o_accel_x,
    input logic signed [imsc_pkg::AxisW-1:0] o_accel_y,
    input logic signed [imsc_pkg::NegW-1:0]  o_accel_z,
    input logic signed [imsc_pkg::NegW-1:0]  o_gyro_x,
    input logic signed [imsc_pkg::AxisW-1:0] o_gyro_y,
    input logic signed [imsc_pkg::NegW-1:0]  o_gyro_z,
    input logic signed [imsc_pkg::MagW-1:0]  o_mag_x,
    input logic signed [imsc_pkg::MagW-1:0]  o_mag_y,
    input logic signed [imsc_pkg::MagW-1:0]  o_mag_z
);

    logic imu_zero, mag_zero;

    assign imu_zero = (o_accel_x == '0) && (o_accel_y == '0) && (o_accel_z == '0)
                   && (o_gyro_x == '0) && (o_gyro_y == '0) && (o_gyro_z == '0);
    assign mag_zero = (o_mag_x == '0) && (o_mag_y == '0) && (o_mag_z == '0);

    // reset flushes the pipe
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // no vector delivered: every data field is zero
    a_stale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fresh) |-> (imu_zero && mag_zero))
        else $error("data on a word without a fresh vector");

    // the other sensor's fields stay zero
    a_kind_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == imsc_pkg::KIND_IMU) ? mag_zero : imu_zero))
        else $error("fields of the other sensor not zero");

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_kind) && $stable(o_fresh)
                                   && $stable(o_mag_x) && $stable(o_accel_x)))
        else $error("stalled output word changed");

endmodule

bind imu_mag_sample_conditioner imsc_checker u_imsc_checker (.*);

/* bench/imu_mag_sample_conditioner_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// imu_mag_sample_conditioner_test: self-checking bench for the conditioner
// Drives sensor burst words through the valid/ready input, programs the APB
// registers between phases, and compares every output word field by field
// against an in-bench model of decode, sensor health and mag calibration.
// ============================================================================
module imu_mag_sample_conditioner_test;
    import imsc_pkg::*;

    localparam int          PipeDepth  = 3;        // accept to o_valid
    localparam int          CycleLimit = 200000;
    localparam logic [2:0]  REG_SPARE  = 3'd7;     // unmapped, writes dropped

    // one burst-read word as driven on the input channel
    typedef struct {
        logic              action;
        logic              read_ok;
        logic [BytesW-1:0] accel;
        logic [BytesW-1:0] gyro;
        logic [BytesW-1:0] mag;
        logic [7:0]        st1;
        logic [7:0]        st2;
    } sensor_word_t;

    // one conditioned output word
    typedef struct {
        logic                    kind;
        logic signed [NegW-1:0]  accel_x;
        logic signed [AxisW-1:0] accel_y;
        logic signed [NegW-1:0]  accel_z;
        logic signed [NegW-1:0]  gyro_x;
        logic signed [AxisW-1:0] gyro_y;
        logic signed [NegW-1:0]  gyro_z;
        logic signed [MagW-1:0]  mag_x;
        logic signed [MagW-1:0]  mag_y;
        logic signed [MagW-1:0]  mag_z;
        logic                    fresh;
        logic [1:0]              alive;
    } cond_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register shadow, sensor health model, pending output words
    // ------------------------------------------------------------------------
    class cond_scoreboard;
        logic             imu_present, mag_present;
        logic [7:0]       miss_limit;
        logic [RowW-1:0]  cal_row[3];
        logic [OffsW-1:0] cal_offset;
        logic             imu_alive, mag_alive;
        logic [7:0]       imu_misses, mag_misses;
        cond_result_t     pending[$];
        int unsigned      n_words, n_results, n_errors, n_writes;
        int unsigned      n_imu_fresh, n_mag_fresh, n_clipped;

        function new();
            imu_present = 1'b1;
            mag_present = 1'b1;
            miss_limit  = MissLimitRst;
            foreach (cal_row[r]) cal_row[r] = '0;
            cal_offset  = '0;
            imu_alive   = 1'b1;
            mag_alive   = 1'b1;
            imu_misses  = '0;
            mag_misses  = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [DataW-1:0] value);
            n_writes++;
            case (idx)
                REG_IMU_PRESENT: imu_present = value[0];
                REG_MAG_PRESENT: mag_present = value[0];
                REG_MISS_LIMIT:  miss_limit  = value[7:0];
                REG_CAL_ROW0:    cal_row[0]  = value[RowW-1:0];
                REG_CAL_ROW1:    cal_row[1]  = value[RowW-1:0];
                REG_CAL_ROW2:    cal_row[2]  = value[RowW-1:0];
                REG_CAL_OFFSET:  cal_offset  = value[OffsW-1:0];
                default: ;
            endcase
        endfunction

        // one row of A dotted with d (Q4), rounded half up to Q16, clipped
        function logic signed [MagW-1:0] calibrated_axis(logic [RowW-1:0] row,
                                                         longint d0, longint d1,
                                                         longint d2);
            logic signed [CoefW-1:0] c0, c1, c2;
            longint                  s;
            c0 = row[CoefW-1:0];
            c1 = row[2*CoefW-1:CoefW];
            c2 = row[3*CoefW-1:2*CoefW];
            s = longint'(c0) * d0 + longint'(c1) * d1 + longint'(c2) * d2;
            s = (s + 2048) >>> FracDrop;
            if (s > MagMax) begin
                s = MagMax;
                n_clipped++;
            end else if (s < MagMin) begin
                s = MagMin;
                n_clipped++;
            end
            return s[MagW-1:0];
        endfunction

        // expected output word for one accepted input word; updates health
        function cond_result_t conditioned(sensor_word_t w);
            cond_result_t             r;
            logic signed [AxisW-1:0]  ax, ay, az, gx, gy, gz, rx, ry, rz;
            logic signed [OffW-1:0]   b0, b1, b2;
            longint                   neg, d0, d1, d2;
            r = '{default: 0};
            r.kind = w.action;
            if (w.action == KIND_IMU) begin
                if (imu_present && imu_alive) begin
                    if (w.read_ok) begin
                        // big-endian axes, x and z flipped
                        ax = w.accel[47:32];
                        ay = w.accel[31:16];
                        az = w.accel[15:0];
                        gx = w.gyro[47:32];
                        gy = w.gyro[31:16];
                        gz = w.gyro[15:0];
                        neg = -longint'(ax);
                        r.accel_x = neg[NegW-1:0];
                        r.accel_y = ay;
                        neg = -longint'(az);
                        r.accel_z = neg[NegW-1:0];
                        neg = -longint'(gx);
                        r.gyro_x = neg[NegW-1:0];
                        r.gyro_y = gy;
                        neg = -longint'(gz);
                        r.gyro_z = neg[NegW-1:0];
                        imu_misses = '0;
                        r.fresh = 1'b1;
                        n_imu_fresh++;
                    end else begin
                        imu_misses = (imu_misses == MissMax) ? MissMax : imu_misses + 8'd1;
                        if (imu_misses > miss_limit) imu_alive = 1'b0;
                    end
                end
            end else if (mag_present && mag_alive) begin
                if (!w.read_ok) begin
                    mag_misses = (mag_misses == MissMax) ? MissMax : mag_misses + 8'd1;
                    if (mag_misses > miss_limit) mag_alive = 1'b0;
                end else if (w.st1[DrdyBit] && !w.st2[OvfBit]) begin
                    // little-endian pairs, then x' = -y, y' = x, z' = z
                    rx = {w.mag[39:32], w.mag[47:40]};
                    ry = {w.mag[23:16], w.mag[31:24]};
                    rz = {w.mag[7:0],   w.mag[15:8]};
                    b0 = cal_offset[OffW-1:0];
                    b1 = cal_offset[2*OffW-1:OffW];
                    b2 = cal_offset[3*OffW-1:2*OffW];
                    d0 = -16 * longint'(ry) - longint'(b0);
                    d1 =  16 * longint'(rx) - longint'(b1);
                    d2 =  16 * longint'(rz) - longint'(b2);
                    r.mag_x = calibrated_axis(cal_row[0], d0, d1, d2);
                    r.mag_y = calibrated_axis(cal_row[1], d0, d1, d2);
                    r.mag_z = calibrated_axis(cal_row[2], d0, d1, d2);
                    mag_misses = '0;
                    r.fresh = 1'b1;
                    n_mag_fresh++;
                end
            end
            r.alive = {mag_present & mag_alive, imu_present & imu_alive};
            return r;
        endfunction

        function void note_word(sensor_word_t w);
            n_words++;
            pending.push_back(conditioned(w));
        endfunction

        function void match_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (got !== want) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("MISMATCH word %0d %s: expected %0d, got %0d",
                             n_results, name, want, got);
            end
        endfunction

        function void check_result(cond_result_t got);
            cond_result_t want;
            if (pending.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("MISMATCH output word with nothing pending");
                return;
            end
            want = pending.pop_front();
            match_field("kind",    64'(want.kind),    64'(got.kind));
            match_field("accel_x", 64'(want.accel_x), 64'(got.accel_x));
            match_field("accel_y", 64'(want.accel_y), 64'(got.accel_y));
            match_field("accel_z", 64'(want.accel_z), 64'(got.accel_z));
            match_field("gyro_x",  64'(want.gyro_x),  64'(got.gyro_x));
            match_field("gyro_y",  64'(want.gyro_y),  64'(got.gyro_y));
            match_field("gyro_z",  64'(want.gyro_z),  64'(got.gyro_z));
            match_field("mag_x",   64'(want.mag_x),   64'(got.mag_x));
            match_field("mag_y",   64'(want.mag_y),   64'(got.mag_y));
            match_field("mag_z",   64'(want.mag_z),   64'(got.mag_z));
            match_field("fresh",   64'(want.fresh),   64'(got.fresh));
            match_field("alive",   64'(want.alive),   64'(got.alive));
            n_results++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                    i_clk, i_rst_n;
    logic                    i_valid, o_ready;
    logic                    i_action, i_read_ok;
    logic [BytesW-1:0]       i_accel_bytes, i_gyro_bytes, i_mag_bytes;
    logic [7:0]              i_mag_status1, i_mag_status2;
    logic                    o_valid, i_ready;
    logic                    o_kind;
    logic signed [NegW-1:0]  o_accel_x, o_accel_z, o_gyro_x, o_gyro_z;
    logic signed [AxisW-1:0] o_accel_y, o_gyro_y;
    logic signed [MagW-1:0]  o_mag_x, o_mag_y, o_mag_z;
    logic                    o_fresh;
    logic [1:0]              o_alive_flags;
    logic                    psel, penable, pwrite, pready;
    logic [AddrW-1:0]        paddr;
    logic [DataW-1:0]        pwdata, prdata;

    imu_mag_sample_conditioner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_read_ok     (i_read_ok),
        .i_accel_bytes (i_accel_bytes),
        .i_gyro_bytes  (i_gyro_bytes),
        .i_mag_bytes   (i_mag_bytes),
        .i_mag_status1 (i_mag_status1),
        .i_mag_status2 (i_mag_status2),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_accel_x     (o_accel_x),
        .o_accel_y     (o_accel_y),
        .o_accel_z     (o_accel_z),
        .o_gyro_x      (o_gyro_x),
        .o_gyro_y      (o_gyro_y),
        .o_gyro_z      (o_gyro_z),
        .o_mag_x       (o_mag_x),
        .o_mag_y       (o_mag_y),
        .o_mag_z       (o_mag_z),
        .o_fresh       (o_fresh),
        .o_alive_flags (o_alive_flags),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cond_scoreboard sb;
    cond_result_t   seen_word;
    int unsigned    send_gap_pct, sink_stall_pct;   // idle odds per cycle
    int unsigned    sink_hold;                      // forced i_ready-low cycles
    int unsigned    cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake or missing output word ends the run here
    initial begin
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Output side: i_ready picked at the falling edge. A pending hold forces
    // a long stall so the pipe fills and o_ready has to drop.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                i_ready <= 1'b0;
                sink_hold--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // output monitor: every word taken at a rising edge is checked in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            seen_word.kind    = o_kind;
            seen_word.accel_x = o_accel_x;
            seen_word.accel_y = o_accel_y;
            seen_word.accel_z = o_accel_z;
            seen_word.gyro_x  = o_gyro_x;
            seen_word.gyro_y  = o_gyro_y;
            seen_word.gyro_z  = o_gyro_z;
            seen_word.mag_x   = o_mag_x;
            seen_word.mag_y   = o_mag_y;
            seen_word.mag_z   = o_mag_z;
            seen_word.fresh   = o_fresh;
            seen_word.alive   = o_alive_flags;
            sb.check_result(seen_word);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers (all entered and left at a falling edge)
    // ------------------------------------------------------------------------

    // APB write: setup cycle, then access until pready; idle cycle after
    task automatic apb_write(logic [2:0] idx, logic [DataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // 1-bit enables get junk in the unused upper bits
    task automatic write_flag(logic [2:0] idx, logic value);
        logic [DataW-1:0] v;
        v = {$urandom, $urandom};
        v[0] = value;
        apb_write(idx, v);
    endtask

    function automatic logic signed [CoefW-1:0] rand_signed(int unsigned bits);
        logic signed [CoefW-1:0] v;
        v = CoefW'($urandom);
        v = v >>> (CoefW - $urandom_range(2, bits));
        return v;
    endfunction

    // random A and b; coef_bits bounds coefficient size (small = few clips)
    task automatic write_random_cal(int unsigned coef_bits);
        logic [CoefW-1:0] c0, c1, c2;
        logic [CoefW-1:0] o0, o1, o2;
        for (int r = 0; r < 3; r++) begin
            c0 = rand_signed(coef_bits);
            c1 = rand_signed(coef_bits);
            c2 = rand_signed(coef_bits);
            apb_write(REG_CAL_ROW0 + 3'(r), {1'b0, c2, c1, c0});
        end
        o0 = rand_signed(OffW);
        o1 = rand_signed(OffW);
        o2 = rand_signed(OffW);
        apb_write(REG_CAL_OFFSET, {4'h0, o2[OffW-1:0], o1[OffW-1:0], o0[OffW-1:0]});
    endtask

    task automatic send_word(sensor_word_t w);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= w.action;
        i_read_ok     <= w.read_ok;
        i_accel_bytes <= w.accel;
        i_gyro_bytes  <= w.gyro;
        i_mag_bytes   <= w.mag;
        i_mag_status1 <= w.st1;
        i_mag_status2 <= w.st2;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic send_fields(logic act, logic ok, logic [BytesW-1:0] acc,
                               logic [BytesW-1:0] gyr, logic [BytesW-1:0] mag,
                               logic [7:0] s1, logic [7:0] s2);
        sensor_word_t w;
        w.action  = act;
        w.read_ok = ok;
        w.accel   = acc;
        w.gyro    = gyr;
        w.mag     = mag;
        w.st1     = s1;
        w.st2     = s2;
        send_word(w);
    endtask

    // axis value with extra weight on the corners
    function automatic logic [AxisW-1:0] pick_axis();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly complete reads with fresh, clean mag status; some failed reads,
    // some stale or overflowed mag samples
    function automatic sensor_word_t random_word(int unsigned fail_pct,
                                                 int unsigned junk_pct);
        sensor_word_t w;
        w.action  = 1'($urandom);
        w.read_ok = ($urandom_range(0, 99) >= fail_pct);
        w.accel   = {pick_axis(), pick_axis(), pick_axis()};
        w.gyro    = {pick_axis(), pick_axis(), pick_axis()};
        w.mag     = {pick_axis(), pick_axis(), pick_axis()};
        w.st1     = 8'($urandom);
        w.st2     = 8'($urandom);
        w.st1[DrdyBit] = 1'b1;
        w.st2[OvfBit]  = 1'b0;
        if ($urandom_range(0, 99) < junk_pct) begin
            case ($urandom_range(0, 2))
                0: w.st1[DrdyBit] = 1'b0;
                1: w.st2[OvfBit]  = 1'b1;
                default: begin
                    w.st1[DrdyBit] = 1'b0;
                    w.st2[OvfBit]  = 1'b1;
                end
            endcase
        end
        return w;
    endfunction

    task automatic run_random(int unsigned count, int unsigned fail_pct,
                              int unsigned junk_pct);
        for (int unsigned n = 0; n < count; n++)
            send_word(random_word(fail_pct, junk_pct));
    endtask

    // drop valid, wait for every pending word, then let the pipe settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (PipeDepth + 2) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sensor_word_t w;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = KIND_IMU;
        i_read_ok      = 1'b0;
        i_accel_bytes  = '0;
        i_gyro_bytes   = '0;
        i_mag_bytes    = '0;
        i_mag_status1  = '0;
        i_mag_status2  = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_gap_pct   = 22;
        sink_stall_pct = 53;
        sink_hold      = 0;
        sb = new();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Diagonal A of 2^-8 and b = 0: a full-scale axis lands exactly on
        // the Q8.16 limits, +32768 clipping to the top code.
        write_flag(REG_IMU_PRESENT, 1'b1);
        write_flag(REG_MAG_PRESENT, 1'b1);
        apb_write(REG_MISS_LIMIT, 64'd50);
        apb_write(REG_CAL_ROW0, {1'b0, 21'd0, 21'd0, 21'h010000});
        apb_write(REG_CAL_ROW1, {1'b0, 21'd0, 21'h010000, 21'd0});
        apb_write(REG_CAL_ROW2, {1'b0, 21'h010000, 21'd0, 21'd0});
        apb_write(REG_CAL_OFFSET, 64'd0);
        apb_write(REG_SPARE, '1);   // unmapped, must change nothing

        // directed: axis corners, misses, stale / overflowed mag data
        send_fields(KIND_IMU, 1, 48'h800080008000, 48'h800080008000, 0, 0, 0);
        send_fields(KIND_IMU, 1, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 0, 0, 0);
        send_fields(KIND_IMU, 1, 48'h000000000000, 48'hFFFFFFFFFFFF, 0, 0, 0);
        send_fields(KIND_IMU, 1, 48'h0123456789AB, 48'hFEDCBA987654, 0, 0, 0);
        send_fields(KIND_IMU, 0, 48'h123412341234, 48'h432143214321, 0, 0, 0);
        send_fields(KIND_IMU, 0, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 0, 0, 0);
        send_fields(KIND_IMU, 1, 48'h00010002FFFE, 48'h8001FFFF0001, 0, 0, 0);
        send_fields(KIND_MAG, 1, 0, 0, 48'h008000800080, 8'h01, 8'h00);
        send_fields(KIND_MAG, 1, 0, 0, 48'hFF7FFF7FFF7F, 8'h01, 8'h00);
        send_fields(KIND_MAG, 1, 0, 0, 48'h000000000000, 8'hFF, 8'hF7);
        send_fields(KIND_MAG, 1, 0, 0, 48'h123456789ABC, 8'hFE, 8'h00);
        send_fields(KIND_MAG, 1, 0, 0, 48'h123456789ABC, 8'h01, 8'h08);
        send_fields(KIND_MAG, 1, 0, 0, 48'h123456789ABC, 8'h00, 8'hFF);
        send_fields(KIND_MAG, 0, 0, 0, 48'h123456789ABC, 8'h01, 8'h00);
        send_fields(KIND_MAG, 0, 0, 0, 48'hFFFFFFFFFFFF, 8'hFF, 8'h00);
        send_fields(KIND_MAG, 1, 0, 0, 48'h34127856BC9A, 8'h01, 8'h00);
        send_fields(KIND_IMU, 0, 48'h555555555555, 48'hAAAAAAAAAAAA, 0, 0, 0);
        wait_drained();

        // miss limit at 255: counters pin at 255 and the sensors survive
        apb_write(REG_MISS_LIMIT, 64'd255);
        write_random_cal(14);
        run_random(200, 10, 10);
        for (int n = 0; n < 258; n++) begin
            w = random_word(100, 0);
            w.action = KIND_IMU;
            send_word(w);
        end
        for (int n = 0; n < 258; n++) begin
            w = random_word(100, 0);
            w.action = KIND_MAG;
            send_word(w);
        end
        // good reads clear both counters before the limit comes down
        w = random_word(0, 0);
        w.action = KIND_IMU;
        send_word(w);
        w.action = KIND_MAG;
        send_word(w);
        wait_drained();

        // accel/gyro absent; A at its largest, b at its most negative
        write_flag(REG_IMU_PRESENT, 1'b0);
        apb_write(REG_MISS_LIMIT, 64'($urandom_range(20, 200)));
        apb_write(REG_CAL_ROW0, {1'b0, {3{21'h0FFFFF}}});
        apb_write(REG_CAL_ROW1, {1'b0, {3{21'h0FFFFF}}});
        apb_write(REG_CAL_ROW2, {1'b0, {3{21'h0FFFFF}}});
        apb_write(REG_CAL_OFFSET, {4'h0, {3{20'h80000}}});
        run_random(200, 10, 15);
        wait_drained();

        // swap the idle odds; magnetometer absent, A and b at the other end
        send_gap_pct   = 53;
        sink_stall_pct = 22;
        write_flag(REG_IMU_PRESENT, 1'b1);
        write_flag(REG_MAG_PRESENT, 1'b0);
        apb_write(REG_CAL_ROW0, {1'b0, {3{21'h100000}}});
        apb_write(REG_CAL_ROW1, {1'b0, {3{21'h100000}}});
        apb_write(REG_CAL_ROW2, {1'b0, {3{21'h100000}}});
        apb_write(REG_CAL_OFFSET, {4'h0, {3{20'h7FFFF}}});
        run_random(200, 10, 15);
        wait_drained();

        write_flag(REG_MAG_PRESENT, 1'b1);
        apb_write(REG_MISS_LIMIT, 64'd254);
        write_random_cal(16);
        run_random(200, 10, 15);
        wait_drained();

        // no idling; start with a long output stall so the pipe backs up
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        apb_write(REG_MISS_LIMIT, 64'($urandom_range(20, 254)));
        write_random_cal(21);
        sink_hold = 80;
        run_random(250, 10, 10);
        wait_drained();

        // tight limits last: sensors die here and stay dead
        apb_write(REG_MISS_LIMIT, 64'd1);
        write_random_cal(12);
        run_random(120, 25, 10);
        wait_drained();

        apb_write(REG_MISS_LIMIT, 64'd0);
        run_random(30, 30, 10);
        send_fields(KIND_IMU, 0, 48'h111122223333, 48'h444455556666, 0, 0, 0);
        send_fields(KIND_MAG, 0, 0, 0, 48'h111122223333, 8'h01, 8'h00);
        send_fields(KIND_IMU, 1, 48'h7FFF80000001, 48'h80007FFFFFFF, 0, 0, 0);
        send_fields(KIND_MAG, 1, 0, 0, 48'h008000800080, 8'h01, 8'h00);
        wait_drained();

        $display("Run: %0d words in, %0d checked, %0d register writes; %0d accel/gyro and %0d mag vectors, %0d mag axes clipped",
                 sb.n_words, sb.n_results, sb.n_writes, sb.n_imu_fresh,
                 sb.n_mag_fresh, sb.n_clipped);
        $display("Covered absent and dead sensors, miss limits 0/1/255, stale and overflowed samples, full back-pressure; %0d mismatches",
                 sb.n_errors);
        if (sb.n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/imsc_pkg.sv
design/imsc_health.sv
design/imsc_cal.sv
design/imu_mag_sample_conditioner.sv
design/imsc_checker.sv
bench/imu_mag_sample_conditioner_test.sv
